// ===== rtl/mtrhn_pkg.sv =====
// Types, constants and a helper function shared by the held-notes router.
package mtrhn_pkg;

   localparam int PORTS      = 4;
   localparam int CHANNELS   = 16;
   localparam int BANKS      = 2;
   localparam int BANK_KEYS  = 64;
   localparam int KEY_W      = 7;
   localparam int BIT_W      = $clog2(BANK_KEYS);
   localparam int ROWS       = PORTS * CHANNELS * BANKS;
   localparam int ADDR_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ROW_CODE_W = 7;

   localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
   localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
   localparam logic       OP_ROUTE     = 1'b0;
   localparam logic       OP_FLUSH     = 1'b1;

   typedef struct packed {
      logic              op;
      logic [1:0]        port;
      logic [3:0]        channel;
      logic [7:0]        status;
      logic [6:0]        data1;
      logic [6:0]        data2;
      logic signed [7:0] transpose;
      logic              muted;
      logic              key_bank;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] out_port;
      logic [7:0] out_status;
      logic [6:0] out_data1;
      logic [6:0] out_data2;
      logic       last;
   } rsp_payload_type;

   typedef struct packed {
      logic load_item;
      logic ram_read;
      logic ram_write;
      logic load_word;
      logic emit_route;
      logic emit_flush;
   } dp_cmd_type;

   typedef struct packed {
      logic op;
      logic muted;
      logic port_ok;
      logic out_free;
      logic word_zero;
      logic word_last;
   } dp_status_type;

   // Index of the lowest set bit of a bank word.
   function automatic logic [BIT_W-1:0] lowest_index(input logic [BANK_KEYS-1:0] word);
      logic [BANK_KEYS-1:0] onehot;
      logic [BIT_W-1:0]     idx;
      onehot = word & (~word + BANK_KEYS'(1));
      idx    = '0;
      for (int i = 0; i < BANK_KEYS; i++) begin
         if (onehot[i]) begin
            idx = idx | BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== rtl/mtrhn_if.sv =====
// Handshake interfaces for the request and response item channels.
interface mtrhn_req_if;
   logic                     valid;
   logic                     ready;
   mtrhn_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mtrhn_rsp_if;
   logic                     valid;
   logic                     ready;
   mtrhn_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/mtrhn_ram.sv =====
// Generic single-port RAM with registered read data.
module mtrhn_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mtrhn_dp.sv =====
// Datapath: item registers, key transposition, held-key memory, bank scan and response register.
module mtrhn_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  mtrhn_pkg::req_payload_type req_payload,
   input  logic                       rsp_ready,
   input  mtrhn_pkg::dp_cmd_type      cmd,
   output mtrhn_pkg::dp_status_type   stat,
   output mtrhn_pkg::rsp_payload_type rsp_payload,
   output logic                       rsp_valid
);

   mtrhn_pkg::req_payload_type       item_ff, item_in;
   logic [mtrhn_pkg::KEY_W-1:0]      key_ff, key_in;
   logic [mtrhn_pkg::BANK_KEYS-1:0]  word_ff, word_in;
   logic [mtrhn_pkg::ROWS-1:0]       valid_ff, valid_in;
   mtrhn_pkg::rsp_payload_type       rsp_ff, rsp_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   logic [3:0]                          nib;
   logic [3:0]                          in_nib;
   logic [mtrhn_pkg::KEY_W-1:0]         sum_key;
   logic                                bank;
   logic [mtrhn_pkg::ROW_CODE_W-1:0]    row_code;
   logic [mtrhn_pkg::ADDR_W-1:0]        addr;
   logic [mtrhn_pkg::BANK_KEYS-1:0]     rd_word;
   logic [mtrhn_pkg::BANK_KEYS-1:0]     rd_data;
   logic [mtrhn_pkg::BANK_KEYS-1:0]     key_bit;
   logic [mtrhn_pkg::BANK_KEYS-1:0]     wr_word;
   logic [mtrhn_pkg::BANK_KEYS-1:0]     word_rest;
   logic                                out_free;

   assign in_nib  = req_payload.status[7:4];
   assign sum_key = mtrhn_pkg::KEY_W'(req_payload.data1 + req_payload.transpose[6:0]);
   assign nib     = item_ff.status[7:4];

   assign bank     = (item_ff.op == mtrhn_pkg::OP_FLUSH) ? item_ff.key_bank : key_ff[6];
   assign row_code = {item_ff.port, item_ff.channel, bank};
   assign addr     = mtrhn_pkg::ADDR_W'(row_code);

   mtrhn_ram #(
      .WIDTH (mtrhn_pkg::BANK_KEYS),
      .DEPTH (mtrhn_pkg::ROWS)
   ) u_held_ram (
      .clock   (clock),
      .rd_en   (cmd.ram_read),
      .wr_en   (cmd.ram_write),
      .addr    (addr),
      .wr_data (wr_word),
      .rd_data (rd_data)
   );

   // A row never written since reset reads as no keys held.
   assign rd_word = valid_ff[addr] ? rd_data : '0;
   assign key_bit = mtrhn_pkg::BANK_KEYS'(1) << key_ff[mtrhn_pkg::BIT_W-1:0];

   always_comb begin
      if (item_ff.op == mtrhn_pkg::OP_FLUSH) begin
         wr_word = '0;
      end else if (nib == mtrhn_pkg::NIB_NOTE_ON) begin
         wr_word = rd_word | key_bit;
      end else if (nib == mtrhn_pkg::NIB_NOTE_OFF) begin
         wr_word = rd_word & ~key_bit;
      end else begin
         wr_word = rd_word;
      end
   end

   assign word_rest = word_ff & (word_ff - mtrhn_pkg::BANK_KEYS'(1));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      item_in      = item_ff;
      key_in       = key_ff;
      word_in      = word_ff;
      valid_in     = valid_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.load_item) begin
         item_in = req_payload;
         key_in  = (in_nib <= mtrhn_pkg::NIB_NOTE_ON) ? sum_key : req_payload.data1;
      end
      if (cmd.ram_write) begin
         valid_in[addr] = 1'b1;
      end
      if (cmd.load_word) begin
         word_in = rd_word;
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit_route) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_port    = item_ff.port;
         rsp_in.out_status  = {nib, item_ff.channel};
         rsp_in.out_data1   = key_ff;
         rsp_in.out_data2   = item_ff.data2;
         rsp_in.last        = 1'b0;
      end
      if (cmd.emit_flush) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_port    = item_ff.port;
         rsp_in.out_status  = {mtrhn_pkg::NIB_NOTE_OFF, item_ff.channel};
         rsp_in.out_data1   = {item_ff.key_bank, mtrhn_pkg::lowest_index(word_ff)};
         rsp_in.out_data2   = '0;
         rsp_in.last        = (word_rest == '0);
         word_in            = word_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      key_ff  <= key_in;
      word_ff <= word_in;
      rsp_ff  <= rsp_in;
   end

   assign stat.op        = item_ff.op;
   assign stat.muted     = item_ff.muted;
   assign stat.port_ok   = (32'(item_ff.port) < mtrhn_pkg::PORTS);
   assign stat.out_free  = out_free;
   assign stat.word_zero = (word_ff == '0);
   assign stat.word_last = (word_rest == '0);

   assign rsp_payload = rsp_ff;
   assign rsp_valid   = rsp_valid_ff;

endmodule

// ===== rtl/mtrhn_ctrl.sv =====
// Controller state machine sequencing the route and flush operations.
module mtrhn_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  mtrhn_pkg::dp_status_type stat,
   output mtrhn_pkg::dp_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_MODIFY = 3'd2;
   localparam logic [2:0] S_EMIT   = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_READ;
            end
         end
         S_READ: begin
            if (stat.op == mtrhn_pkg::OP_FLUSH && !stat.port_ok) begin
               state_in = S_IDLE;
            end else begin
               cmd.ram_read = stat.port_ok;
               state_in     = S_MODIFY;
            end
         end
         S_MODIFY: begin
            cmd.ram_write = stat.port_ok;
            if (stat.op == mtrhn_pkg::OP_FLUSH) begin
               cmd.load_word = 1'b1;
               state_in      = S_SCAN;
            end else if (stat.muted) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_route = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_SCAN: begin
            if (stat.word_zero) begin
               state_in = S_IDLE;
            end else if (stat.out_free) begin
               cmd.emit_flush = 1'b1;
               if (stat.word_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/midi_track_router_held_notes_unit.sv =====
// Top level of the MIDI track router with held-key tracking and bank flush.
//
// Channel    Direction  Content
// req_chan   in         one route or flush request item
// rsp_chan   out        one routed event or flush note-off item
//
// A route item steps through accept, memory read, read-modify-write and response states.
// A muted route item ends after the read-modify-write, as it has no response.
// A flush item reads and clears its bitmap, then emits one note-off per held key (none if empty).
// The held-key memory is read and written through its single port.
// Reset is synchronous; a per-row valid bit makes every bitmap read as empty after reset.
// A stalled response holds the sequencer; a new item is taken once the last result is registered.
module midi_track_router_held_notes_unit (
   input logic         clock,
   input logic         reset,
   mtrhn_req_if.sink   req_chan,
   mtrhn_rsp_if.source rsp_chan
);

   mtrhn_pkg::dp_cmd_type    cmd;
   mtrhn_pkg::dp_status_type stat;

   mtrhn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mtrhn_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_chan.payload),
      .rsp_ready   (rsp_chan.ready),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_chan.payload),
      .rsp_valid   (rsp_chan.valid)
   );

endmodule
